// File: hw/rtl/b2nv_pkg.sv
// Shared types, constants and arithmetic helpers for the BGR to NV21 converter.
package b2nv_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int DIM_W    = 13;
    localparam int COUNT_W  = 12;
    localparam int LADDR_W  = 24;
    localparam int CADDR_W  = 25;
    localparam int PIX_W    = 8;
    localparam int CFG_IDX_W = 8;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [CADDR_W-1:0] PLANE_BASE_RESET = 25'd307200;

    // BT.601 coefficients in 0.14 fixed point.
    localparam logic [13:0] COEF_BY = 14'd1868;
    localparam logic [13:0] COEF_GY = 14'd9617;
    localparam logic [13:0] COEF_RY = 14'd4899;
    localparam logic [13:0] COEF_BU = 14'd9241;
    localparam logic [13:0] COEF_RV = 14'd11682;
    localparam int FRAC_BITS = 14;
    localparam logic signed [24:0] CHROMA_BIAS = 25'sd2097152;

    // Per-pixel addresses and flags that travel beside the color data.
    typedef struct packed {
        logic [LADDR_W-1:0] luma_addr;
        logic               chroma_valid;
        logic [CADDR_W-1:0] chroma_addr;
        logic               frame_last;
    } pix_tag_t;

    function automatic logic size_ok(input logic [DIM_W-1:0] v, input int maxv);
        return (v >= DIM_W'(2)) && (v <= DIM_W'(maxv)) && !v[0];
    endfunction

    // Scales (comp - y) by coef, adds the 128 offset and saturates to a byte.
    function automatic logic [PIX_W-1:0] chroma_scale(
        input logic [PIX_W-1:0] comp,
        input logic [PIX_W-1:0] y,
        input logic [13:0]      coef
    );
        logic signed [9:0]  diff;
        logic signed [24:0] sum;
        logic [10:0]        whole;
        diff  = signed'({2'b00, comp}) - signed'({2'b00, y});
        sum   = diff * signed'({1'b0, coef}) + CHROMA_BIAS;
        whole = sum[24:FRAC_BITS];
        if (sum[24]) begin
            return '0;
        end else if (whole > 11'd255) begin
            return 8'hFF;
        end
        return whole[PIX_W-1:0];
    endfunction

endpackage

// File: hw/rtl/bgr_to_nv21_converter.sv
// Top level of the BGR to NV21 converter: configuration, raster counters and output packing.
//
//  channel  direction  handshake              payload
//  s_       in         s_tvalid / s_tready    s_tdata: blue, green, red
//  m_       out        m_tvalid / m_tready    m_tdata, m_tuser, m_tlast
//  cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel is accepted per clock while s_tready is high; it passes the luma multiplier
// stage, then the chroma multiplier stage. A stall on m_tready holds both stages and
// drops s_tready only when the pipeline is full; s_tready is also low while a
// configuration write is offered.
// Reset is synchronous; it sets a 640x480 frame and restarts the raster.
// While either dimension is invalid, pixels are accepted and discarded.
module bgr_to_nv21_converter
    import b2nv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // blue[7:0], green[15:8], red[23:16]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [79:0]          m_tdata,   // luma[7:0], luma_addr[31:8], chroma_v[39:32],
                                            // chroma_u[47:40], chroma_addr[72:48], zeros above
    output logic                 m_tuser,   // chroma_valid
    output logic                 m_tlast,   // frame_last
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [CADDR_W-1:0] plane_base_reg, plane_base_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic [COUNT_W-1:0] col_reg, col_next;
    logic [LADDR_W-1:0] luma_ptr_reg, luma_ptr_next;
    logic [CADDR_W-1:0] chroma_ptr_reg, chroma_ptr_next;

    logic       cfg_write, cfg_hit, frame_ok, pix_accept, pix_take;
    logic       chroma_here, last_col, last_pix;
    logic [2*DIM_W-1:0] area;
    pix_tag_t   pix_tag, out_tag;
    logic       csc_ready;
    logic [PIX_W-1:0] out_luma, out_v, out_u;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // A pixel never transfers in the same cycle as a configuration write.
    assign frame_ok   = size_ok(width_reg, MAX_WIDTH) && size_ok(height_reg, MAX_HEIGHT);
    assign s_tready   = csc_ready && !cfg_valid;
    assign pix_accept = s_tvalid && s_tready;
    assign pix_take   = pix_accept && frame_ok;

    assign chroma_here = !row_reg[0] && !col_reg[0];
    assign last_col    = ({1'b0, col_reg} + DIM_W'(1)) >= width_reg;
    assign last_pix    = last_col && (({1'b0, row_reg} + DIM_W'(1)) >= height_reg);

    always_comb begin
        pix_tag.luma_addr    = luma_ptr_reg;
        pix_tag.chroma_valid = chroma_here;
        pix_tag.chroma_addr  = chroma_here ? chroma_ptr_reg : '0;
        pix_tag.frame_last   = last_pix;
    end

    // A write to either size register also restarts the frame.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        cfg_hit     = 1'b0;
        if (cfg_write) begin
            case (cfg_index)
                REG_FRAME_WIDTH: begin
                    width_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                REG_FRAME_HEIGHT: begin
                    height_next = cfg_data;
                    cfg_hit     = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        area            = width_next * height_next;
        plane_base_next = cfg_hit ? area[CADDR_W-1:0] : plane_base_reg;
    end

    always_comb begin
        row_next        = row_reg;
        col_next        = col_reg;
        luma_ptr_next   = luma_ptr_reg;
        chroma_ptr_next = chroma_ptr_reg;
        if (cfg_hit) begin
            row_next        = '0;
            col_next        = '0;
            luma_ptr_next   = '0;
            chroma_ptr_next = plane_base_next;
        end else if (pix_take) begin
            if (last_pix) begin
                row_next        = '0;
                col_next        = '0;
                luma_ptr_next   = '0;
                chroma_ptr_next = plane_base_reg;
            end else begin
                luma_ptr_next = luma_ptr_reg + LADDR_W'(1);
                if (chroma_here) begin
                    chroma_ptr_next = chroma_ptr_reg + CADDR_W'(2);
                end
                if (last_col) begin
                    col_next = '0;
                    row_next = row_reg + COUNT_W'(1);
                end else begin
                    col_next = col_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            plane_base_reg <= PLANE_BASE_RESET;
            row_reg        <= '0;
            col_reg        <= '0;
            luma_ptr_reg   <= '0;
            chroma_ptr_reg <= PLANE_BASE_RESET;
        end else begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            plane_base_reg <= plane_base_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            luma_ptr_reg   <= luma_ptr_next;
            chroma_ptr_reg <= chroma_ptr_next;
        end
    end

    b2nv_csc u_csc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && !cfg_valid && frame_ok),
        .in_ready  (csc_ready),
        .in_blue   (s_tdata[7:0]),
        .in_green  (s_tdata[15:8]),
        .in_red    (s_tdata[23:16]),
        .in_tag    (pix_tag),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_luma  (out_luma),
        .out_v     (out_v),
        .out_u     (out_u),
        .out_tag   (out_tag)
    );

    assign m_tdata = {7'd0, out_tag.chroma_addr, out_u, out_v, out_tag.luma_addr, out_luma};
    assign m_tuser = out_tag.chroma_valid;
    assign m_tlast = out_tag.frame_last;

endmodule

// File: hw/rtl/b2nv_csc.sv
// Two-stage color conversion pipeline: luma in the first stage, chroma in the second.
module b2nv_csc
    import b2nv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] in_blue,
    input  logic [PIX_W-1:0] in_green,
    input  logic [PIX_W-1:0] in_red,
    input  pix_tag_t         in_tag,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_luma,
    output logic [PIX_W-1:0] out_v,
    output logic [PIX_W-1:0] out_u,
    output pix_tag_t         out_tag
);

    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_y_reg, s1_r_reg, s1_b_reg;
    pix_tag_t         s1_tag_reg;
    logic             o_valid_reg, o_valid_next;
    logic [PIX_W-1:0] o_luma_reg, o_v_reg, o_u_reg;
    pix_tag_t         o_tag_reg;

    logic             out_advance, s1_advance;
    logic [21:0]      y_sum;
    logic [PIX_W-1:0] v_calc, u_calc;

    assign out_advance = !o_valid_reg || out_ready;
    assign s1_advance  = !s1_valid_reg || out_advance;
    assign in_ready    = s1_advance;

    assign y_sum = 22'(COEF_BY) * 22'(in_blue) + 22'(COEF_GY) * 22'(in_green)
                 + 22'(COEF_RY) * 22'(in_red);

    assign v_calc = chroma_scale(s1_r_reg, s1_y_reg, COEF_RV);
    assign u_calc = chroma_scale(s1_b_reg, s1_y_reg, COEF_BU);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        o_valid_next  = o_valid_reg;
        if (s1_advance) begin
            s1_valid_next = in_valid;
        end
        if (out_advance) begin
            o_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && in_valid) begin
            s1_y_reg   <= y_sum[21:FRAC_BITS];
            s1_r_reg   <= in_red;
            s1_b_reg   <= in_blue;
            s1_tag_reg <= in_tag;
        end
        if (out_advance && s1_valid_reg) begin
            o_luma_reg <= s1_y_reg;
            o_v_reg    <= s1_tag_reg.chroma_valid ? v_calc : '0;
            o_u_reg    <= s1_tag_reg.chroma_valid ? u_calc : '0;
            o_tag_reg  <= s1_tag_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_luma  = o_luma_reg;
    assign out_v     = o_v_reg;
    assign out_u     = o_u_reg;
    assign out_tag   = o_tag_reg;

endmodule
